// ===== src/bale_pkg.sv =====
`default_nettype none

package bale_pkg;

    localparam int BALE_CAPACITY = 16;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DISPLAY = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

`default_nettype wire

// ===== src/bounded_array_list_engine.sv =====
// Channel   Handshake                  Payload
// input     in_valid / in_stall        mode, item_value, item_position
// output    out_valid / out_stall      status, result_value, result_position,
//                                      element_total, last_of_run
//
// One item at a time; the store has one write and one registered read port,
// so each moved or scanned element takes a read state and then a write,
// compare or output state.
// Reset clears the count and control; store contents are undefined until written.
// Output stall holds the output register and the sequencer waits on it.

`default_nettype none

module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int CAPACITY = BALE_CAPACITY
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [MODE_W-1:0]          mode,
    input  wire logic signed [DATA_W-1:0]   item_value,
    input  wire logic [POS_W-1:0]           item_position,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [STATUS_W-1:0]             status,
    output logic signed [DATA_W-1:0]        result_value,
    output logic [POS_W-1:0]                result_position,
    output logic [POS_W-1:0]                element_total,
    output logic                            last_of_run
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DISP_RD,
        S_DISP_OUT,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [WW-1:0]          pos_m1_reg, pos_m1_next;
    logic [DATA_W-1:0]      key_reg, key_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [DATA_W-1:0]      res_value_reg, res_value_next;
    logic [POS_W-1:0]       res_pos_reg, res_pos_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [DATA_W-1:0]      out_value_reg, out_value_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;
    logic [POS_W-1:0]       out_total_reg, out_total_next;
    logic                   out_last_reg, out_last_next;

    logic [DATA_W-1:0]      mem_array [CAPACITY];
    logic [DATA_W-1:0]      rd_data_reg;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [DATA_W-1:0]      wr_data;
    logic [AW-1:0]          rd_addr;

    logic                   load_ok;
    logic                   full;
    logic                   empty;
    logic [WW-1:0]          in_pos_m1;
    logic [WW-1:0]          count_w;
    logic [WW-1:0]          idx_w;
    logic [CW-1:0]          idx_p1;
    logic [CW-1:0]          idx_m1;
    logic [WW-1:0]          idx_p1_w;

    assign load_ok   = !out_valid_reg || !out_stall;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign in_pos_m1 = WW'(item_position) - WW'(1);
    assign count_w   = WW'(count_reg);
    assign idx_w     = WW'(idx_reg);
    assign idx_p1    = idx_reg + CW'(1);
    assign idx_m1    = idx_reg - CW'(1);
    assign idx_p1_w  = WW'(idx_p1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_m1_next     = pos_m1_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = rd_data_reg;
        rd_addr         = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = in_pos_m1[AW-1:0];
                if (in_valid)
                begin
                    pos_m1_next     = in_pos_m1;
                    key_next        = item_value;
                    idx_next        = '0;
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    res_pos_next    = '0;
                    case (mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_EMIT;
                        end
                        MODE_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = item_value;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = S_EMIT;
                        end
                        MODE_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (item_position == '0 || in_pos_m1 > count_w)
                            begin
                                res_status_next = ST_BAD_POS;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else if (item_position == '0 || in_pos_m1 >= count_w)
                            begin
                                res_status_next = ST_BAD_POS;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DEL_CAP;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        MODE_DISPLAY:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DISP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (idx_w > pos_m1_reg)
                begin
                    rd_addr    = idx_m1[AW-1:0];
                    state_next = S_INS_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_m1_reg[AW-1:0];
                    wr_data    = key_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_EMIT;
                end
            end
            S_INS_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_m1;
                state_next = S_INS_RD;
            end
            S_DEL_CAP:
            begin
                res_value_next = rd_data_reg;
                idx_next       = pos_m1_reg[CW-1:0];
                state_next     = S_DEL_RD;
            end
            S_DEL_RD:
            begin
                if (idx_p1 < count_reg)
                begin
                    rd_addr    = idx_p1[AW-1:0];
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_EMIT;
                end
            end
            S_DEL_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_p1;
                state_next = S_DEL_RD;
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    res_pos_next = idx_p1_w[POS_W-1:0];
                    state_next   = S_EMIT;
                end
                else if (idx_p1 == count_reg)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = S_SRCH_RD;
                end
            end
            S_DISP_RD:
            begin
                state_next = S_DISP_OUT;
            end
            S_DISP_OUT:
            begin
                if (load_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_value_next  = rd_data_reg;
                    out_pos_next    = idx_p1_w[POS_W-1:0];
                    out_total_next  = count_w[POS_W-1:0];
                    out_last_next   = (idx_p1 == count_reg);
                    if (idx_p1 == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_p1;
                        state_next = S_DISP_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_pos_next    = res_pos_reg;
                    out_total_next  = count_w[POS_W-1:0];
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pos_m1_reg     <= '0;
            key_reg        <= '0;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
            res_pos_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_value_reg  <= '0;
            out_pos_reg    <= '0;
            out_total_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pos_m1_reg     <= pos_m1_next;
            key_reg        <= key_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            res_pos_reg    <= res_pos_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_pos_reg    <= out_pos_next;
            out_total_reg  <= out_total_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign result_value    = out_value_reg;
    assign result_position = out_pos_reg;
    assign element_total   = out_total_reg;
    assign last_of_run     = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the list");

    a_unused_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode > MODE_DISPLAY) |=> !in_stall)
        else $error("unused mode left the sequencer busy");

    a_run_body_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> (status == ST_OK))
        else $error("non-final item carries an error status");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import bale_pkg::*;
();

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         total;
        logic                     is_last;
    } list_result_t;

    class list_tracker;
        logic signed [DATA_W-1:0] elems [BALE_CAPACITY];
        int                       count;
        list_result_t             due[$];
        int                       mismatches;
        int                       results_seen;
        int                       ops_done;
        int                       refusals;

        function new();
            count        = 0;
            mismatches   = 0;
            results_seen = 0;
            ops_done     = 0;
            refusals     = 0;
        endfunction

        function void expect_one(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] v,
                                 int p, bit is_last);
            list_result_t r;
            r.status   = st;
            r.value    = v;
            r.position = POS_W'(p);
            r.total    = POS_W'(count);
            r.is_last  = is_last;
            due.push_back(r);
            if (st != ST_OK)
            begin
                refusals++;
            end
        endfunction

        function void note_item(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v,
                                logic [POS_W-1:0] p);
            int                       pos;
            int                       found;
            logic signed [DATA_W-1:0] removed;
            pos = p;
            if (m > MODE_DISPLAY)
            begin
                return;
            end
            ops_done++;
            case (m)
                MODE_CLEAR:
                begin
                    count = 0;
                    expect_one(ST_OK, 0, 0, 1'b1);
                end
                MODE_APPEND:
                begin
                    if (count >= BALE_CAPACITY)
                    begin
                        expect_one(ST_FULL, 0, 0, 1'b1);
                    end
                    else
                    begin
                        elems[count] = v;
                        count++;
                        expect_one(ST_OK, 0, 0, 1'b1);
                    end
                end
                MODE_INSERT:
                begin
                    if (count >= BALE_CAPACITY)
                    begin
                        expect_one(ST_FULL, 0, 0, 1'b1);
                    end
                    else if (pos == 0 || pos > count + 1)
                    begin
                        expect_one(ST_BAD_POS, 0, 0, 1'b1);
                    end
                    else
                    begin
                        for (int i = count; i >= pos; i--)
                        begin
                            elems[i] = elems[i - 1];
                        end
                        elems[pos - 1] = v;
                        count++;
                        expect_one(ST_OK, 0, 0, 1'b1);
                    end
                end
                MODE_DELETE:
                begin
                    if (count == 0)
                    begin
                        expect_one(ST_EMPTY, 0, 0, 1'b1);
                    end
                    else if (pos == 0 || pos > count)
                    begin
                        expect_one(ST_BAD_POS, 0, 0, 1'b1);
                    end
                    else
                    begin
                        removed = elems[pos - 1];
                        for (int i = pos - 1; i + 1 < count; i++)
                        begin
                            elems[i] = elems[i + 1];
                        end
                        count--;
                        expect_one(ST_OK, removed, 0, 1'b1);
                    end
                end
                MODE_SEARCH:
                begin
                    if (count == 0)
                    begin
                        expect_one(ST_EMPTY, 0, 0, 1'b1);
                    end
                    else
                    begin
                        found = 0;
                        for (int i = 0; i < count; i++)
                        begin
                            if (found == 0 && elems[i] == v)
                            begin
                                found = i + 1;
                            end
                        end
                        if (found != 0)
                        begin
                            expect_one(ST_OK, 0, found, 1'b1);
                        end
                        else
                        begin
                            expect_one(ST_NOT_FOUND, 0, 0, 1'b1);
                        end
                    end
                end
                default:
                begin
                    if (count == 0)
                    begin
                        expect_one(ST_EMPTY, 0, 0, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < count; i++)
                        begin
                            expect_one(ST_OK, elems[i], i + 1, i + 1 == count);
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            results_seen++;
            if (due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: st=%0d val=%0d pos=%0d tot=%0d last=%0b",
                             got.status, got.value, got.position, got.total, got.is_last);
                end
                return;
            end
            want = due.pop_front();
            if (got.status !== want.status || got.value !== want.value ||
                got.position !== want.position || got.total !== want.total ||
                got.is_last !== want.is_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected st=%0d val=%0d pos=%0d tot=%0d last=%0b",
                             want.status, want.value, want.position, want.total, want.is_last);
                    $display("          got      st=%0d val=%0d pos=%0d tot=%0d last=%0b",
                             got.status, got.value, got.position, got.total, got.is_last);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         item_position;
    logic                     out_valid;
    logic                     out_stall;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] result_value;
    logic [POS_W-1:0]         result_position;
    logic [POS_W-1:0]         element_total;
    logic                     last_of_run;

    list_tracker ledger = new();
    bit          calm;
    int          items_sent;

    bounded_array_list_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .item_value      (item_value),
        .item_position   (item_position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .result_value    (result_value),
        .result_position (result_position),
        .element_total   (element_total),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            ledger.note_item(mode, item_value, item_position);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            ledger.check_result('{status, result_value, result_position, element_total,
                                  last_of_run});
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        int near;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            near = $urandom_range(0, 4);
            return near - 2;
        end
        if (r < 40)
        begin
            return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        return $urandom();
    endfunction

    // mostly a legal position in 1..hi, sometimes anything the field holds
    function automatic logic [POS_W-1:0] pick_position(int hi);
        if (hi >= 1 && $urandom_range(0, 9) < 8)
        begin
            return POS_W'($urandom_range(1, hi));
        end
        return POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_key();
        if (ledger.count > 0 && $urandom_range(0, 9) < 6)
        begin
            return ledger.elems[$urandom_range(0, ledger.count - 1)];
        end
        return pick_value();
    endfunction

    // receiver: random stalls separated by stall-free runs
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            int idle;
            int hold;
            idle = $urandom_range(1, 8);
            repeat (idle) @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v,
                             input logic [POS_W-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        item_value    <= v;
        item_position <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (m <= MODE_DISPLAY)
        begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.due.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int base;
        int pick;
        bit drained;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        mode          <= MODE_CLEAR;
        item_value    <= '0;
        item_position <= '0;
        calm       = 1'b0;
        items_sent = 0;
        drained    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, extremes, spare modes, full list
        send_item(MODE_DISPLAY, 0, 0);
        send_item(MODE_DELETE, 0, 1);
        send_item(MODE_SEARCH, 0, 0);
        send_item(MODE_INSERT, 5, 0);
        send_item(MODE_INSERT, 5, 2);
        send_item(MODE_INSERT, 32'sh8000_0000, 1);
        send_item(MODE_APPEND, 32'sh7FFF_FFFF, 0);
        send_item(MODE_SPARE_LO, 32'sh7FFF_FFFF, 5'h1F);
        send_item(MODE_SPARE_HI, -1, 1);
        send_item(MODE_SEARCH, 32'sh7FFF_FFFF, 0);
        send_item(MODE_INSERT, -1, 3);
        while (ledger.count < BALE_CAPACITY)
        begin
            send_item(MODE_APPEND, ledger.count * 7, 0);
        end
        send_item(MODE_APPEND, 1, 0);
        send_item(MODE_INSERT, 1, 1);
        send_item(MODE_DISPLAY, 0, 0);
        send_item(MODE_DELETE, 0, 0);
        send_item(MODE_DELETE, 0, 17);
        send_item(MODE_DELETE, 0, 16);
        send_item(MODE_SEARCH, 1000, 0);
        send_item(MODE_CLEAR, 0, 0);

        base = items_sent;
        while (items_sent < base + 110)
        begin
            calm = (items_sent >= base + 60) && (items_sent < base + 90);
            if (!drained && items_sent >= base + 100)
            begin
                wait_drained();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                while (ledger.count < BALE_CAPACITY)
                begin
                    send_item(MODE_APPEND, pick_value(), pick_position(0));
                end
                send_item(MODE_INSERT, pick_value(), pick_position(ledger.count + 1));
            end
            else if (pick < 7)
            begin
                while (ledger.count > 0)
                begin
                    send_item(MODE_DELETE, pick_value(),
                              POS_W'($urandom_range(1, ledger.count)));
                end
            end
            else if (pick < 10)
            begin
                send_item($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO, $urandom(),
                          POS_W'($urandom_range(0, 31)));
            end
            else if (pick < 13)
            begin
                send_item(MODE_CLEAR, $urandom(), POS_W'($urandom_range(0, 31)));
            end
            else if (pick < 21)
            begin
                send_item(MODE_DISPLAY, $urandom(), POS_W'($urandom_range(0, 31)));
            end
            else if (pick < 41)
            begin
                send_item(MODE_APPEND, pick_value(), POS_W'($urandom_range(0, 31)));
            end
            else if (pick < 59)
            begin
                send_item(MODE_INSERT, pick_value(), pick_position(ledger.count + 1));
            end
            else if (pick < 77)
            begin
                send_item(MODE_DELETE, pick_value(), pick_position(ledger.count));
            end
            else
            begin
                send_item(MODE_SEARCH, pick_key(), POS_W'($urandom_range(0, 31)));
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Ran %0d list operations (%0d answered with a non-ok status), %0d results.",
                 ledger.ops_done, ledger.refusals, ledger.results_seen);
        if (ledger.mismatches == 0 && ledger.due.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatching results, %0d still outstanding",
                     ledger.mismatches, ledger.due.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", ledger.due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
